@@ design/stm_pkg.sv @@
// ----------------------------------------------------------------------------
// stm_pkg: shared types and constants of the sparse table range-minimum engine
// Field widths, command codes, sequencer states and the level search helper.
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam int VAL_W            = 32;   // element value width
    localparam int RNG_W            = 10;   // query index / result index width
    localparam int LG_W             = 4;    // floor log2 of an RNG_W+1 bit length
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_LEVELS       = 11;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD0,
        ST_LDK,
        ST_QCHK,
        ST_QRD2,
        ST_QCMP
    } t_state;

    // position of the highest set bit of a range length
    function automatic logic [LG_W-1:0] floor_log2(input logic [RNG_W:0] v);
        logic [LG_W-1:0] k;
        k = '0;
        for (int i = 1; i <= RNG_W; i++) begin
            if (v[i]) begin
                k = LG_W'(i);
            end
        end
        return k;
    endfunction

endpackage

@@ design/stm_if.sv @@
// ----------------------------------------------------------------------------
// stm_if: valid/ready channels of the sparse table range-minimum engine
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface stm_in_if
    import stm_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [VAL_W-1:0] element_value;
    logic                    last_element;
    logic [RNG_W-1:0]        range_left;
    logic [RNG_W-1:0]        range_right;

    modport source (
        output valid, command, element_value, last_element, range_left, range_right,
        input  ready
    );
    modport sink (
        input  valid, command, element_value, last_element, range_left, range_right,
        output ready
    );
endinterface

interface stm_out_if
    import stm_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] min_value;
    logic [RNG_W-1:0]        min_index;
    logic                    range_error;

    modport source (
        output valid, min_value, min_index, range_error,
        input  ready
    );
    modport sink (
        input  valid, min_value, min_index, range_error,
        output ready
    );
endinterface

@@ design/stm_mem.sv @@
// ----------------------------------------------------------------------------
// stm_mem: sparse table storage
// Window minimum and first index per level and window start; one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module stm_mem
    import stm_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS,
    parameter int DEPTH  = DEF_MAX_ELEMENTS,
    parameter int IDX_W  = $clog2(DEF_MAX_ELEMENTS)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(LEVELS)-1:0]   i_wlvl,
    input  logic [IDX_W-1:0]            i_wpos,
    input  logic signed [VAL_W-1:0]     i_wval,
    input  logic [IDX_W-1:0]            i_widx,
    input  logic                        i_re,
    input  logic [$clog2(LEVELS)-1:0]   i_rlvl,
    input  logic [IDX_W-1:0]            i_rpos,
    output logic signed [VAL_W-1:0]     o_rval,
    output logic [IDX_W-1:0]            o_ridx
);

    logic signed [VAL_W-1:0] r_val_mem [LEVELS][DEPTH];
    logic [IDX_W-1:0]        r_idx_mem [LEVELS][DEPTH];
    logic signed [VAL_W-1:0] r_rval;
    logic [IDX_W-1:0]        r_ridx;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_val_mem[i_wlvl][i_wpos] <= i_wval;
            r_idx_mem[i_wlvl][i_wpos] <= i_widx;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rval <= r_val_mem[i_rlvl][i_rpos];
            r_ridx <= r_idx_mem[i_rlvl][i_rpos];
        end
    end

    assign o_rval = r_rval;
    assign o_ridx = r_ridx;

endmodule

@@ design/stm_cmp.sv @@
// ----------------------------------------------------------------------------
// stm_cmp: shared minimum unit
// Picks the smaller of two signed window minima; ties keep the left operand.
// ----------------------------------------------------------------------------
module stm_cmp
    import stm_pkg::*;
#(
    parameter int IDX_W = $clog2(DEF_MAX_ELEMENTS)
) (
    input  logic signed [VAL_W-1:0] i_a_val,
    input  logic [IDX_W-1:0]        i_a_idx,
    input  logic signed [VAL_W-1:0] i_b_val,
    input  logic [IDX_W-1:0]        i_b_idx,
    output logic signed [VAL_W-1:0] o_min_val,
    output logic [IDX_W-1:0]        o_min_idx
);

    logic take_a;

    assign take_a    = (i_a_val <= i_b_val);
    assign o_min_val = take_a ? i_a_val : i_b_val;
    assign o_min_idx = take_a ? i_a_idx : i_b_idx;

endmodule

@@ design/sparse_table_range_min.sv @@
// ----------------------------------------------------------------------------
// sparse_table_range_min: range-minimum engine on a sparse table
// Loads append elements and fill one table entry per level; queries combine
// two overlapping power-of-two windows.
//
//  channel | dir | transfer payload
//  i_in    | in  | command, element_value, last_element, range_left, range_right
//  o_out   | out | min_value, min_index, range_error (one per query)
//
// A load at position p writes levels 0 to min(floor_log2(p+1), LEVELS-1), one
// table write per level through the single write port and the shared minimum
// unit, each level's operand fetched while the level below is written. A query
// makes two reads over the one read port, then one compare; a query with bad
// bounds skips the reads. No new transfer is taken until a command finishes.
// A finished query result waits in the output register, loads go on meanwhile;
// a further query holds in its compare state while that register is full.
// Reset clears only state, count, closed flag and output valid; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module sparse_table_range_min
    import stm_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int LEVELS       = DEF_LEVELS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stm_in_if.sink    i_in,
    stm_out_if.source o_out
);

    localparam int POS_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SPAN_W = LEVELS;
    localparam int SW     = (POS_W > SPAN_W) ? POS_W : SPAN_W;
    localparam int CW     = (CNT_W > RNG_W + 1) ? CNT_W : RNG_W + 1;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_closed, n_closed;
    logic                    r_cmd, n_cmd;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [POS_W-1:0]        r_pos, n_pos;
    logic [RNG_W-1:0]        r_left, n_left;
    logic [RNG_W-1:0]        r_right, n_right;
    logic [LVL_W-1:0]        r_k, n_k;
    logic [POS_W-1:0]        r_start, n_start;
    logic [SPAN_W-1:0]       r_span, n_span;
    logic signed [VAL_W-1:0] r_run_val, n_run_val;
    logic [POS_W-1:0]        r_run_idx, n_run_idx;
    logic                    r_err, n_err;
    logic                    r_o_valid, n_o_valid;
    logic signed [VAL_W-1:0] r_o_val, n_o_val;
    logic [RNG_W-1:0]        r_o_idx, n_o_idx;
    logic                    r_o_err, n_o_err;

    logic                    mem_we, mem_re;
    logic [LVL_W-1:0]        mem_wlvl, mem_rlvl;
    logic [POS_W-1:0]        mem_wpos, mem_rpos;
    logic signed [VAL_W-1:0] mem_wval, mem_rval;
    logic [POS_W-1:0]        mem_widx, mem_ridx;

    logic signed [VAL_W-1:0] cmp_a_val, cmp_b_val, cmp_min_val;
    logic [POS_W-1:0]        cmp_a_idx, cmp_b_idx, cmp_min_idx;

    logic                    accept;
    logic                    full;
    logic                    can_next;
    logic [SW-1:0]           start_next;
    logic                    q_err;
    logic [RNG_W:0]          q_len;
    logic [LG_W-1:0]         q_lg;
    logic [LVL_W-1:0]        q_k;
    logic [RNG_W:0]          q_span;
    logic [RNG_W:0]          q_start2;

    stm_mem #(
        .LEVELS (LEVELS),
        .DEPTH  (MAX_ELEMENTS),
        .IDX_W  (POS_W)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_wlvl (mem_wlvl),
        .i_wpos (mem_wpos),
        .i_wval (mem_wval),
        .i_widx (mem_widx),
        .i_re   (mem_re),
        .i_rlvl (mem_rlvl),
        .i_rpos (mem_rpos),
        .o_rval (mem_rval),
        .o_ridx (mem_ridx)
    );

    stm_cmp #(
        .IDX_W (POS_W)
    ) u_cmp (
        .i_a_val   (cmp_a_val),
        .i_a_idx   (cmp_a_idx),
        .i_b_val   (cmp_b_val),
        .i_b_idx   (cmp_b_idx),
        .o_min_val (cmp_min_val),
        .o_min_idx (cmp_min_idx)
    );

    assign i_in.ready        = (r_state == ST_IDLE);
    assign accept            = i_in.valid && i_in.ready;
    assign o_out.valid       = r_o_valid;
    assign o_out.min_value   = r_o_val;
    assign o_out.min_index   = r_o_idx;
    assign o_out.range_error = r_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_closed  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_closed  <= n_closed;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_left    <= n_left;
        r_right   <= n_right;
        r_k       <= n_k;
        r_start   <= n_start;
        r_span    <= n_span;
        r_run_val <= n_run_val;
        r_run_idx <= n_run_idx;
        r_err     <= n_err;
        r_o_val   <= n_o_val;
        r_o_idx   <= n_o_idx;
        r_o_err   <= n_o_err;
    end

    // level step and query bound arithmetic
    assign full       = !r_closed && (r_count == CNT_W'(MAX_ELEMENTS));
    assign start_next = SW'(r_start) - SW'(r_span);
    assign can_next   = (r_k != LVL_W'(LEVELS - 1)) && (SW'(r_start) >= SW'(r_span));
    assign q_err      = !r_closed || (r_left > r_right) || (CW'(r_right) >= CW'(r_count));
    assign q_len      = {1'b0, r_right} - {1'b0, r_left} + (RNG_W + 1)'(1);
    assign q_lg       = floor_log2(q_len);
    assign q_k        = (int'(q_lg) > LEVELS - 1) ? LVL_W'(LEVELS - 1) : LVL_W'(q_lg);
    assign q_span     = (RNG_W + 1)'(1) << q_k;
    assign q_start2   = {1'b0, r_right} + (RNG_W + 1)'(1) - q_span;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_closed  = r_closed;
        n_cmd     = r_cmd;
        n_val     = r_val;
        n_pos     = r_pos;
        n_left    = r_left;
        n_right   = r_right;
        n_k       = r_k;
        n_start   = r_start;
        n_span    = r_span;
        n_run_val = r_run_val;
        n_run_idx = r_run_idx;
        n_err     = r_err;
        n_o_valid = r_o_valid && !o_out.ready;
        n_o_val   = r_o_val;
        n_o_idx   = r_o_idx;
        n_o_err   = r_o_err;

        mem_we    = 1'b0;
        mem_wlvl  = r_k;
        mem_wpos  = r_start;
        mem_wval  = cmp_min_val;
        mem_widx  = cmp_min_idx;
        mem_re    = 1'b0;
        mem_rlvl  = r_k;
        mem_rpos  = r_start;

        // load steps fold the table word into the running window; queries
        // compare the left window against the right one
        cmp_a_val = mem_rval;
        cmp_a_idx = mem_ridx;
        cmp_b_val = r_run_val;
        cmp_b_idx = r_run_idx;
        if (r_state == ST_QCMP) begin
            cmp_a_val = r_run_val;
            cmp_a_idx = r_run_idx;
            cmp_b_val = mem_rval;
            cmp_b_idx = mem_ridx;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd   = i_in.command;
                    n_val   = i_in.element_value;
                    n_left  = i_in.range_left;
                    n_right = i_in.range_right;
                    if (i_in.command == CMD_LOAD) begin
                        // a load after close starts a new array at index 0
                        n_pos    = r_closed ? '0 : POS_W'(r_count);
                        n_closed = i_in.last_element;
                        if (r_closed) begin
                            n_count = CNT_W'(1);
                            n_state = ST_LD0;
                        end else if (full) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_state = ST_LD0;
                        end
                    end else begin
                        n_state = ST_QCHK;
                    end
                end
            end
            ST_LD0: begin
                mem_we    = 1'b1;
                mem_wlvl  = '0;
                mem_wpos  = r_pos;
                mem_wval  = r_val;
                mem_widx  = r_pos;
                n_run_val = r_val;
                n_run_idx = r_pos;
                if (r_pos != '0) begin
                    mem_re   = 1'b1;
                    mem_rlvl = '0;
                    mem_rpos = r_pos - POS_W'(1);
                    n_k      = LVL_W'(1);
                    n_start  = r_pos - POS_W'(1);
                    n_span   = SPAN_W'(2);
                    n_state  = ST_LDK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_LDK: begin
                mem_we    = 1'b1;
                n_run_val = cmp_min_val;
                n_run_idx = cmp_min_idx;
                if (can_next) begin
                    // fetch next level's left half while this level is written
                    mem_re   = 1'b1;
                    mem_rlvl = r_k;
                    mem_rpos = POS_W'(start_next);
                    n_k      = r_k + LVL_W'(1);
                    n_start  = POS_W'(start_next);
                    n_span   = r_span << 1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_QCHK: begin
                n_err = q_err;
                if (q_err) begin
                    n_state = ST_QCMP;
                end else begin
                    mem_re   = 1'b1;
                    mem_rlvl = q_k;
                    mem_rpos = POS_W'(r_left);
                    n_k      = q_k;
                    n_start  = POS_W'(q_start2);
                    n_state  = ST_QRD2;
                end
            end
            ST_QRD2: begin
                mem_re    = 1'b1;
                n_run_val = mem_rval;
                n_run_idx = mem_ridx;
                n_state   = ST_QCMP;
            end
            ST_QCMP: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_err   = r_err;
                    n_o_val   = r_err ? '0 : cmp_min_val;
                    n_o_idx   = r_err ? '0 : RNG_W'(cmp_min_idx);
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // a load always leaves the closed flag as its last marker
    a_load_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.command == CMD_LOAD) |=> (r_closed == $past(i_in.last_element)))
        else $error("closed flag does not follow last load marker");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond table depth");

    a_out_from_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == ST_QCMP))
        else $error("result raised outside compare state");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_err) |-> (r_o_val == '0 && r_o_idx == '0))
        else $error("error result carries nonzero payload");

endmodule
